// ===== sv/bsr_pkg.sv =====
// Shared constants and types for the byte stream reassembler.
// Used by byte_stream_reassembler, bsr_checker and the testbench; depends on nothing else.
`default_nettype none

package bsr_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int INDEX_BITS   = 48;
  localparam int BYTE_BITS    = 8;
  localparam int CAP_BITS     = 7;
  localparam int SLOT_BITS    = $clog2(WINDOW_DEPTH);
  localparam int PEND_BITS    = $clog2(WINDOW_DEPTH + 1);

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(64);

  // Input tdata: stream_index, data_byte; padded to whole bytes.
  localparam int S_FIELD_BITS = INDEX_BITS + BYTE_BITS;
  localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;

  // Output tdata: out_byte, stream_closed, pending_count; padded to whole bytes.
  localparam int M_FIELD_BITS = BYTE_BITS + 1 + PEND_BITS;
  localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DRAIN,
    ST_EMIT,
    ST_STATUS
  } state_t;

endpackage

`default_nettype wire

// ===== sv/byte_stream_reassembler.sv =====
// Byte stream reassembler: puts indexed stream bytes back into order.
// Depends on bsr_pkg for widths, the window depth and the sequencer states.
// Checked by bsr_checker, which is bound to this module.
`default_nettype none

// One request is handled at a time. It is taken in the idle state, and the window
// update (store write, valid bit, end mark, close check) follows. Each released
// byte then takes two steps: the head check, which also reads the byte store at
// the head slot into a read register, and the load of the output register. An
// item that releases none takes the head check and the status result instead.
// Each output load waits while the output side stalls. The output register
// lets the last result wait while the next request is taken. The window
// capacity port is always ready.
module byte_stream_reassembler (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input requests.
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  // tdata from bit 0 up: stream_index, data_byte, zero padding
  input  wire logic [bsr_pkg::S_TDATA_BITS-1:0]  s_tdata,
  // tuser: has_byte
  input  wire logic                              s_tuser,
  // tlast: is_last
  input  wire logic                              s_tlast,
  // Results.
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  // tdata from bit 0 up: out_byte, stream_closed, pending_count, zero padding
  output      logic [bsr_pkg::M_TDATA_BITS-1:0]  m_tdata,
  // tuser: out_valid
  output      logic                              m_tuser,
  // tlast: last_of_run
  output      logic                              m_tlast,
  // Window capacity register.
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [bsr_pkg::CAP_BITS-1:0]      cfg_data
);
  import bsr_pkg::*;

  state_t state, state_next;

  logic [CAP_BITS-1:0]     cap;
  logic [WINDOW_DEPTH-1:0] valid_bits;
  logic [INDEX_BITS-1:0]   next_exp;
  logic [INDEX_BITS-1:0]   end_pos;
  logic                    end_known;
  logic [PEND_BITS-1:0]    pend;
  logic                    closed;
  logic [SLOT_BITS-1:0]    head;

  logic [INDEX_BITS-1:0]   in_idx;
  logic [BYTE_BITS-1:0]    in_data;
  logic                    in_has;
  logic                    in_last;

  logic [BYTE_BITS-1:0]    byte_store [WINDOW_DEPTH];
  logic [BYTE_BITS-1:0]    rd_data;

  // Sequencer controls.
  logic upd_en, rd_en, emit_en, status_en;
  logic out_free, more;

  // Window update datapath.
  logic [CAP_BITS-1:0]    cap_eff;
  logic [INDEX_BITS-1:0]  off;
  logic [INDEX_BITS-1:0]  end_off;
  logic                   in_win;
  logic [SLOT_BITS:0]     slot_sum;
  logic [SLOT_BITS-1:0]   wr_slot;
  logic [INDEX_BITS-1:0]  end_cand;
  logic                   end_rec;
  logic [INDEX_BITS-1:0]  end_pos_upd;
  logic                   end_known_upd;
  logic                   close_upd;

  // Drain datapath.
  logic                   head_valid;
  logic [SLOT_BITS-1:0]   head_inc;
  logic [INDEX_BITS-1:0]  next_inc;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  assign cap_eff  = (cap > CAP_BITS'(WINDOW_DEPTH)) ? CAP_BITS'(WINDOW_DEPTH) : cap;
  assign off      = in_idx - next_exp;
  assign end_off  = end_pos - next_exp;
  assign in_win   = in_has && (off < INDEX_BITS'(cap_eff))
                    && !(end_known && (off >= end_off));

  // off is below the capacity here, so head plus off stays under twice the depth.
  assign slot_sum = {1'b0, head} + {1'b0, off[SLOT_BITS-1:0]};
  assign wr_slot  = (slot_sum >= (SLOT_BITS+1)'(WINDOW_DEPTH))
                    ? SLOT_BITS'(slot_sum - (SLOT_BITS+1)'(WINDOW_DEPTH))
                    : slot_sum[SLOT_BITS-1:0];

  assign end_cand      = in_has ? (in_idx + INDEX_BITS'(1)) : in_idx;
  assign end_rec       = in_last && !end_known;
  assign end_pos_upd   = end_rec ? end_cand : end_pos;
  assign end_known_upd = end_known || end_rec;
  assign close_upd     = end_known_upd && (next_exp == end_pos_upd);

  assign head_valid = valid_bits[head];
  assign head_inc   = (head == SLOT_BITS'(WINDOW_DEPTH - 1)) ? '0 : head + SLOT_BITS'(1);
  assign next_inc   = next_exp + INDEX_BITS'(1);
  assign more       = !closed && head_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DRAIN;
      ST_DRAIN:  state_next = more ? ST_EMIT : ST_STATUS;
      ST_EMIT:   if (out_free) state_next = more ? ST_DRAIN : ST_IDLE;
      ST_STATUS: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    upd_en    = 1'b0;
    rd_en     = 1'b0;
    emit_en   = 1'b0;
    status_en = 1'b0;
    case (state)
      ST_IDLE:   s_tready  = 1'b1;
      ST_UPDATE: upd_en    = !closed;
      ST_DRAIN:  rd_en     = more;
      ST_EMIT:   emit_en   = out_free;
      ST_STATUS: status_en = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_idx  <= s_tdata[INDEX_BITS-1:0];
      in_data <= s_tdata[INDEX_BITS +: BYTE_BITS];
      in_has  <= s_tuser;
      in_last <= s_tlast;
    end
  end

  // Byte store. Writes happen only in the update cycle and reads only in the
  // drain cycle, so the two ports never touch the same entry at once.
  always_ff @(posedge clk) begin
    if (upd_en && in_win) begin
      byte_store[wr_slot] <= in_data;
    end
    if (rd_en) begin
      rd_data <= byte_store[head];
    end
  end

  // Window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap        <= CAP_RESET;
      valid_bits <= '0;
      next_exp   <= '0;
      end_pos    <= '0;
      end_known  <= 1'b0;
      pend       <= '0;
      closed     <= 1'b0;
      head       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      if (upd_en) begin
        if (in_win && !valid_bits[wr_slot]) begin
          valid_bits[wr_slot] <= 1'b1;
          pend                <= pend + PEND_BITS'(1);
        end
        end_pos   <= end_pos_upd;
        end_known <= end_known_upd;
        closed    <= close_upd;
      end
      if (rd_en) begin
        valid_bits[head] <= 1'b0;
        head             <= head_inc;
        next_exp         <= next_inc;
        pend             <= pend - PEND_BITS'(1);
        closed           <= end_known && (next_inc == end_pos);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_en || status_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en || status_en) begin
      m_tdata <= M_TDATA_BITS'({pend, closed, (emit_en ? rd_data : BYTE_BITS'(0))});
      m_tuser <= emit_en;
      m_tlast <= status_en || !more;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bsr_checker.sv =====
// Port-level checks for byte_stream_reassembler, bound to every instance.
// Depends on bsr_pkg for the port widths and the window depth.
`default_nettype none

module bsr_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [bsr_pkg::M_TDATA_BITS-1:0]  m_tdata,
  input wire logic                              m_tuser,
  input wire logic                              m_tlast
);
  import bsr_pkg::*;

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // One request at a time: the block is busy right after taking one.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while the previous one is in work");

  // A status result is always the only and final result of its request.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata[BYTE_BITS-1:0] == '0))
    else $error("status result is not a final, empty result");

  // The pending count never exceeds the window depth.
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[BYTE_BITS+1 +: PEND_BITS] <= PEND_BITS'(WINDOW_DEPTH)))
    else $error("pending count above window depth");

endmodule

bind byte_stream_reassembler bsr_checker u_bsr_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast)
);

`default_nettype wire

// ===== sim/tb_byte_stream_reassembler.sv =====
// Self-checking testbench for byte_stream_reassembler: it predicts every result
// and compares it field by field with what the block returns.
// Depends on bsr_pkg and the byte_stream_reassembler RTL only.
module tb_byte_stream_reassembler;
  timeunit 1ns;
  timeprecision 1ps;
  import bsr_pkg::*;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 out_valid;
    logic                 stream_closed;
    logic [PEND_BITS-1:0] pending;
    logic                 last_of_run;
  } release_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata = '0;
  logic                    s_tuser = 1'b0;
  logic                    s_tlast = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_tdata;
  logic                    m_tuser;
  logic                    m_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CAP_BITS-1:0]     cfg_data = '0;

  byte_stream_reassembler DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted state of the reorder window.
  logic [CAP_BITS-1:0]   win_cap = CAP_RESET;
  logic [BYTE_BITS-1:0]  win_store [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] win_valid = '0;
  logic [INDEX_BITS-1:0] next_index = '0;
  logic [INDEX_BITS-1:0] end_index = '0;
  logic                  end_seen = 1'b0;
  logic [PEND_BITS-1:0]  held_count = '0;
  logic                  closed = 1'b0;
  logic [SLOT_BITS-1:0]  head_slot = '0;

  release_t expected_releases [$];
  int       mismatches = 0;
  bit       steady = 1'b0;
  int       order [WINDOW_DEPTH];

  function automatic void enqueue_release(input release_t r);
    expected_releases = {expected_releases, r};
  endfunction

  function automatic int usable_window();
    return (win_cap > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(win_cap);
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_length();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic shuffle_order(input int n);
    int j;
    int t;
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
  endtask

  // Applies one request to the predicted window and queues the results it causes.
  task automatic reassemble(input logic [INDEX_BITS-1:0] idx, input logic [BYTE_BITS-1:0] data,
                            input logic has, input logic last);
    logic [INDEX_BITS-1:0] offset;
    logic [INDEX_BITS-1:0] span;
    logic [SLOT_BITS-1:0]  slot;
    bit                    accept;
    int                    released;
    release_t              r;
    released = 0;
    if (!closed) begin
      if (has) begin
        offset = idx - next_index;
        span = end_index - next_index;
        accept = offset < INDEX_BITS'(usable_window());
        // Bytes at or beyond a known end are never stored.
        if (end_seen && offset >= span) accept = 1'b0;
        if (accept) begin
          slot = head_slot + offset[SLOT_BITS-1:0];
          win_store[slot] = data;
          if (!win_valid[slot]) begin
            win_valid[slot] = 1'b1;
            held_count++;
          end
        end
      end
      if (last && !end_seen) begin
        end_seen = 1'b1;
        end_index = has ? idx + 1'b1 : idx;
      end
      if (end_seen && next_index == end_index) closed = 1'b1;
      while (!closed && released < WINDOW_DEPTH && win_valid[head_slot]) begin
        r.out_byte = win_store[head_slot];
        win_valid[head_slot] = 1'b0;
        head_slot++;
        next_index++;
        held_count--;
        if (end_seen && next_index == end_index) closed = 1'b1;
        released++;
        r.out_valid = 1'b1;
        r.stream_closed = closed;
        r.pending = held_count;
        r.last_of_run = closed || released == WINDOW_DEPTH || !win_valid[head_slot];
        enqueue_release(r);
      end
    end
    if (released == 0) begin
      r.out_byte = '0;
      r.out_valid = 1'b0;
      r.stream_closed = closed;
      r.pending = held_count;
      r.last_of_run = 1'b1;
      enqueue_release(r);
    end
  endtask

  task automatic push_request(input logic [INDEX_BITS-1:0] idx, input logic [BYTE_BITS-1:0] data,
                              input logic has, input logic last);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {data, idx};
    s_tuser  <= has;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    reassemble(idx, data, has, last);
  endtask

  task automatic wait_idle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (expected_releases.size() != 0) @(posedge clk);
    // Room for a request that is still in the sequencer.
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_BITS-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    win_cap = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic test_window_edges();
    push_request('0, 8'h00, 1'b0, 1'b0);
    push_request('1, 8'hFF, 1'b1, 1'b0);
    push_request('0, 8'hFF, 1'b1, 1'b0);
    push_request(next_index + 63, 8'h00, 1'b1, 1'b0);
    push_request(next_index + 64, 8'hAA, 1'b1, 1'b0);
    // Same slot again: the value is replaced, the count stays.
    push_request(next_index + 63, 8'h5A, 1'b1, 1'b0);
    push_request(next_index + 1, 8'h81, 1'b1, 1'b0);
    push_request(next_index, 8'h7E, 1'b1, 1'b0);
    set_capacity('0);
    push_request(next_index, 8'h11, 1'b1, 1'b0);
    set_capacity('1);
    push_request(next_index + 63, 8'h22, 1'b1, 1'b0);
    push_request(next_index + 64, 8'hDD, 1'b1, 1'b0);
    set_capacity(CAP_BITS'(1));
    push_request(next_index + 1, 8'h33, 1'b1, 1'b0);
    push_request(next_index, 8'h44, 1'b1, 1'b0);
    set_capacity(CAP_BITS'(65));
    push_request(next_index + 64, 8'hCC, 1'b1, 1'b0);
  endtask

  // Fills the whole window behind a hole, then closes the hole.
  task automatic test_full_window();
    logic [INDEX_BITS-1:0] base;
    set_capacity(CAP_BITS'(WINDOW_DEPTH));
    base = next_index;
    shuffle_order(WINDOW_DEPTH - 1);
    for (int i = 0; i < WINDOW_DEPTH - 1; i++)
      push_request(base + 1 + order[i], 8'($urandom), 1'b1, 1'b0);
    push_request(base, 8'($urandom), 1'b1, 1'b0);
  endtask

  task automatic test_random_segments();
    logic [INDEX_BITS-1:0] base;
    int sent;
    int len;
    int w;
    int skip;
    sent = 0;
    while (sent < 50) begin
      if ($urandom_range(0, 9) == 0) set_capacity(CAP_BITS'($urandom_range(1, 127)));
      steady = ($urandom_range(0, 4) == 0);
      w = usable_window();
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w)
                                         : $urandom_range(1, (w < 12) ? w : 12);
      // Sometimes one byte is held back so the window carries a hole forward.
      skip = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : -1;
      base = next_index;
      shuffle_order(len);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_request({16'($urandom), 32'($urandom)}, 8'($urandom),
                       1'($urandom), 1'b0);
        if (order[i] != skip) begin
          push_request(base + order[i], 8'($urandom), 1'b1, 1'b0);
          sent++;
        end
        if ($urandom_range(0, 9) == 0) begin
          push_request(base + order[$urandom_range(0, i)], 8'($urandom), 1'b1, 1'b0);
          sent++;
        end
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_stream_end();
    logic [INDEX_BITS-1:0] base;
    // The end mark rides on a byte outside the window; the mark still counts.
    set_capacity(CAP_BITS'(4));
    base = next_index;
    push_request(base + 6, 8'($urandom), 1'b1, 1'b1);
    push_request(base + 3, 8'($urandom), 1'b0, 1'b1);
    set_capacity(CAP_BITS'(WINDOW_DEPTH));
    push_request(base + 7, 8'($urandom), 1'b1, 1'b0);
    shuffle_order(6);
    for (int i = 0; i < 6; i++)
      push_request(base + 1 + order[i], 8'($urandom), 1'b1, 1'b0);
    push_request(base, 8'($urandom), 1'b1, 1'b0);
    // Once closed, every request gets a single status result.
    push_request(next_index, 8'($urandom), 1'b1, 1'b0);
    push_request(next_index + 1, 8'($urandom), 1'b1, 1'b1);
    push_request('0, 8'h00, 1'b0, 1'b0);
  endtask

  always @(negedge clk) begin
    int stall_left;
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      stall_left = idle_length();
      m_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    release_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_releases.size() == 0) begin
        $error("unexpected result: out_byte %0h, out_valid %0b",
               m_tdata[BYTE_BITS-1:0], m_tuser);
        mismatches++;
      end else begin
        want = expected_releases.pop_front();
        if (m_tdata[BYTE_BITS-1:0] !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, m_tdata[BYTE_BITS-1:0]);
          mismatches++;
        end
        if (m_tuser !== want.out_valid) begin
          $error("out_valid: expected %0b, got %0b", want.out_valid, m_tuser);
          mismatches++;
        end
        if (m_tdata[BYTE_BITS] !== want.stream_closed) begin
          $error("stream_closed: expected %0b, got %0b", want.stream_closed,
                 m_tdata[BYTE_BITS]);
          mismatches++;
        end
        if (m_tdata[BYTE_BITS+1 +: PEND_BITS] !== want.pending) begin
          $error("pending_count: expected %0d, got %0d", want.pending,
                 m_tdata[BYTE_BITS+1 +: PEND_BITS]);
          mismatches++;
        end
        if (m_tlast !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, m_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_window_edges();
    test_full_window();
    test_random_segments();
    test_stream_end();
    @(negedge clk) s_tvalid <= 1'b0;
    for (int c = 0; c < 20000 && expected_releases.size() != 0; c++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_releases.size() != 0)
      $error("%0d expected results never arrived", expected_releases.size());
    if (mismatches == 0 && expected_releases.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bsr_pkg.sv
sv/byte_stream_reassembler.sv
sv/bsr_checker.sv
sim/tb_byte_stream_reassembler.sv
